### hdl/sialu_pkg.sv
// Shared types and constants for the SIMT integer ALU lane.
// Depends on nothing; every other file but sialu_ram refers to it by scoped names.
`timescale 1ns / 1ps

package sialu_pkg;

    localparam int NUM_THREADS = 32;
    localparam int NUM_REGS    = 256;
    localparam int THREAD_W    = $clog2(NUM_THREADS);
    localparam int REG_W       = $clog2(NUM_REGS);
    localparam int RF_DEPTH    = NUM_THREADS * NUM_REGS;
    localparam int RF_ADDR_W   = THREAD_W + REG_W;

    // Bit positions inside the immediate flags.
    localparam int IMM_A_BIT = 2;
    localparam int IMM_B_BIT = 1;
    localparam int IMM_C_BIT = 0;

    typedef enum logic [1:0] {
        MODE_MAD  = 2'd0,
        MODE_LOP3 = 2'd1,
        MODE_SHF  = 2'd2,
        MODE_NOP  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_EXEC,
        ST_WR_HI,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        STEP_A    = 2'd0,
        STEP_B    = 2'd1,
        STEP_C    = 2'd2,
        STEP_C_HI = 2'd3
    } step_t;

    typedef struct packed {
        mode_t      mode;
        logic       wide;
        logic       shift_left;
        logic [7:0] truth_table;
    } exec_ctrl_t;

    typedef struct packed {
        logic [31:0] low_word;
        logic [31:0] high_word;
        logic        pair_written;
    } exec_res_t;

endpackage

### hdl/sialu_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module sialu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/sialu_exec.sv
// Execute unit: multiply-add sum, three-input table logic and funnel shift.
// Depends on sialu_pkg; the product arrives already registered.
`timescale 1ns / 1ps

module sialu_exec (
    input  sialu_pkg::exec_ctrl_t ctrl,
    input  logic [31:0]           op_a,
    input  logic [31:0]           op_b,
    input  logic [63:0]           op_c,
    input  logic [63:0]           prod,
    output sialu_pkg::exec_res_t  res
);

    logic [63:0] mad_sum;
    logic [31:0] lop_word;
    logic [63:0] funnel;
    logic [63:0] shifted;

    assign mad_sum = prod + op_c;

    // Each result bit picks the table entry addressed by {a, b, c}.
    always_comb
    begin
        for (int i = 0; i < 32; i++)
        begin
            lop_word[i] = ctrl.truth_table[{op_a[i], op_b[i], op_c[i]}];
        end
    end

    assign funnel = {op_c[31:0], op_a};

    always_comb
    begin
        if (op_b[31:6] != 26'd0)
        begin
            shifted = 64'd0;
        end
        else if (ctrl.shift_left)
        begin
            shifted = funnel << op_b[5:0];
        end
        else
        begin
            shifted = funnel >> op_b[5:0];
        end
    end

    always_comb
    begin
        res = '0;
        unique case (ctrl.mode)
            sialu_pkg::MODE_MAD:
            begin
                res.low_word = mad_sum[31:0];
                if (ctrl.wide)
                begin
                    res.high_word    = mad_sum[63:32];
                    res.pair_written = 1'b1;
                end
            end
            sialu_pkg::MODE_LOP3:
            begin
                res.low_word = lop_word;
            end
            sialu_pkg::MODE_SHF:
            begin
                res.low_word = shifted[31:0];
            end
            default:
            begin
                res = '0;
            end
        endcase
    end

endmodule

### hdl/simt_integer_alu_lane.sv
// Top level of the SIMT integer ALU lane: sequencer, operand registers and register file.
// Depends on sialu_pkg, sialu_ram and sialu_exec.
`timescale 1ns / 1ps

// Channel   Direction  Transaction
// s_axis    in         one instruction: tdata operands and indices, tuser mode and flags
// m_axis    out        one write-back report: register, low and high words, pair flag
//
// An instruction of mode 0, 1 or 2 occupies the lane through the acceptance, four
// operand steps through the single read port of the register file, a multiply
// state, an execute and write state, an optional second write for the register pair
// of a wide multiply-add, and a hand-over to the output register.
// An instruction of mode 3 is taken and dropped while idle and produces no transaction.
// After reset the lane is idle; the register file is not cleared and holds
// undefined data until written.
// The result waits in its output register, so a stalled master side only holds
// the lane once the next result is ready and the register is still full.

module simt_integer_alu_lane (
    input  logic         clk,
    input  logic         rst_n,

    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // From bit 0: thread[5], dest_reg[8], src_a[32], src_b[32], src_c[64],
    // truth_table[8], zero padding[3].
    input  logic [151:0] s_axis_tdata,
    // From bit 0: mode[2], imm_flags[3], wide[1], shift_left[1].
    input  logic [6:0]   s_axis_tuser,

    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // From bit 0: written_reg[8], low_word[32], high_word[32].
    output logic [71:0]  m_axis_tdata,
    // From bit 0: pair_written[1].
    output logic [0:0]   m_axis_tuser
);

    localparam int TW = sialu_pkg::THREAD_W;
    localparam int RW = sialu_pkg::REG_W;
    localparam int AW = sialu_pkg::RF_ADDR_W;

    // Unpacked input fields.
    logic [TW-1:0] in_thread;
    logic [RW-1:0] in_dest;
    logic [31:0]   in_src_a;
    logic [31:0]   in_src_b;
    logic [63:0]   in_src_c;
    logic [7:0]    in_truth_table;
    logic [1:0]    in_mode;
    logic [2:0]    in_imm_flags;
    logic          in_wide;
    logic          in_shift_left;

    assign in_thread      = s_axis_tdata[4:0];
    assign in_dest        = s_axis_tdata[12:5];
    assign in_src_a       = s_axis_tdata[44:13];
    assign in_src_b       = s_axis_tdata[76:45];
    assign in_src_c       = s_axis_tdata[140:77];
    assign in_truth_table = s_axis_tdata[148:141];
    assign in_mode        = s_axis_tuser[1:0];
    assign in_imm_flags   = s_axis_tuser[4:2];
    assign in_wide        = s_axis_tuser[5];
    assign in_shift_left  = s_axis_tuser[6];

    // Sequencer state.
    sialu_pkg::state_t state_reg, state_next;
    sialu_pkg::step_t  step_reg, step_next;
    sialu_pkg::step_t  rd_step_reg, rd_step_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              out_valid_reg, out_valid_next;

    // Instruction and operand registers.
    logic [TW-1:0]         thread_reg;
    logic [RW-1:0]         dst_reg;
    logic [2:0]            imm_reg;
    sialu_pkg::exec_ctrl_t ctrl_reg;
    logic [31:0]           op_a_reg;
    logic [31:0]           op_b_reg;
    logic [63:0]           op_c_reg;
    logic [63:0]           prod_reg;
    logic [31:0]           res_hi_reg;
    logic                  res_pair_reg;
    logic [31:0]           res_lo_reg;

    // Output register.
    logic [71:0] out_data_reg;
    logic        out_pair_reg;

    // Register file port.
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    logic                 accept;
    logic                 out_load;
    logic                 step_need;
    logic [RW-1:0]        step_index;
    sialu_pkg::exec_res_t exec_res;

    assign accept = s_axis_tvalid && s_axis_tready;

    // Decide whether the current operand step needs the register file and which
    // register it addresses. The funnel shift always reads a and c from registers
    // and takes b as the shift amount.
    always_comb
    begin
        step_need  = 1'b0;
        step_index = '0;
        unique case (step_reg)
            sialu_pkg::STEP_A:
            begin
                step_need  = (ctrl_reg.mode == sialu_pkg::MODE_SHF)
                             || !imm_reg[sialu_pkg::IMM_A_BIT];
                step_index = op_a_reg[RW-1:0];
            end
            sialu_pkg::STEP_B:
            begin
                step_need  = (ctrl_reg.mode != sialu_pkg::MODE_SHF)
                             && !imm_reg[sialu_pkg::IMM_B_BIT];
                step_index = op_b_reg[RW-1:0];
            end
            sialu_pkg::STEP_C:
            begin
                step_need  = (ctrl_reg.mode == sialu_pkg::MODE_SHF)
                             || !imm_reg[sialu_pkg::IMM_C_BIT];
                step_index = op_c_reg[RW-1:0];
            end
            sialu_pkg::STEP_C_HI:
            begin
                // The upper addend word comes from the next register, wrapping
                // round within the thread's file.
                step_need  = (ctrl_reg.mode == sialu_pkg::MODE_MAD) && ctrl_reg.wide
                             && !imm_reg[sialu_pkg::IMM_C_BIT];
                step_index = op_c_reg[RW-1:0] + RW'(1);
            end
            default:
            begin
                step_need  = 1'b0;
                step_index = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sialu_pkg::ST_IDLE;
            step_reg      <= sialu_pkg::STEP_A;
            rd_step_reg   <= sialu_pkg::STEP_A;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            rd_step_reg   <= rd_step_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        rd_step_next   = rd_step_reg;
        rd_valid_next  = 1'b0;
        out_valid_next = out_valid_reg;
        s_axis_tready  = 1'b0;
        ram_re         = 1'b0;
        ram_raddr      = {thread_reg, step_index};
        ram_we         = 1'b0;
        ram_waddr      = {thread_reg, dst_reg};
        ram_wdata      = exec_res.low_word;
        out_load       = 1'b0;

        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            sialu_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
                step_next     = sialu_pkg::STEP_A;
                // A no-operation instruction is taken and dropped here.
                if (s_axis_tvalid && (in_mode != sialu_pkg::MODE_NOP))
                begin
                    state_next = sialu_pkg::ST_READ;
                end
            end
            sialu_pkg::ST_READ:
            begin
                ram_re        = step_need;
                rd_valid_next = step_need;
                rd_step_next  = step_reg;
                if (step_reg == sialu_pkg::STEP_C_HI)
                begin
                    state_next = sialu_pkg::ST_MUL;
                end
                else
                begin
                    step_next = sialu_pkg::step_t'(step_reg + 2'd1);
                end
            end
            sialu_pkg::ST_MUL:
            begin
                state_next = sialu_pkg::ST_EXEC;
            end
            sialu_pkg::ST_EXEC:
            begin
                ram_we = 1'b1;
                if (exec_res.pair_written)
                begin
                    state_next = sialu_pkg::ST_WR_HI;
                end
                else
                begin
                    state_next = sialu_pkg::ST_DONE;
                end
            end
            sialu_pkg::ST_WR_HI:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {thread_reg, dst_reg + RW'(1)};
                ram_wdata  = res_hi_reg;
                state_next = sialu_pkg::ST_DONE;
            end
            sialu_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = sialu_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sialu_pkg::ST_IDLE;
            end
        endcase
    end

    // Payload registers. Immediates are loaded on acceptance and replaced by
    // register reads in the cycle after each read is issued.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            thread_reg           <= in_thread;
            dst_reg              <= in_dest;
            imm_reg              <= in_imm_flags;
            ctrl_reg.mode        <= sialu_pkg::mode_t'(in_mode);
            ctrl_reg.wide        <= in_wide;
            ctrl_reg.shift_left  <= in_shift_left;
            ctrl_reg.truth_table <= in_truth_table;
            op_a_reg             <= in_src_a;
            op_b_reg             <= in_src_b;
            op_c_reg             <= in_src_c;
        end
        if (rd_valid_reg)
        begin
            case (rd_step_reg)
                sialu_pkg::STEP_A:    op_a_reg         <= ram_rdata;
                sialu_pkg::STEP_B:    op_b_reg         <= ram_rdata;
                sialu_pkg::STEP_C:    op_c_reg         <= {32'd0, ram_rdata};
                default:              op_c_reg[63:32]  <= ram_rdata;
            endcase
        end
        if (state_reg == sialu_pkg::ST_MUL)
        begin
            prod_reg <= {32'd0, op_a_reg} * {32'd0, op_b_reg};
        end
        if (state_reg == sialu_pkg::ST_EXEC)
        begin
            res_lo_reg   <= exec_res.low_word;
            res_hi_reg   <= exec_res.high_word;
            res_pair_reg <= exec_res.pair_written;
        end
        if (out_load)
        begin
            out_data_reg <= {res_hi_reg, res_lo_reg, dst_reg};
            out_pair_reg <= res_pair_reg;
        end
    end

    sialu_exec u_exec (
        .ctrl (ctrl_reg),
        .op_a (op_a_reg),
        .op_b (op_b_reg),
        .op_c (op_c_reg),
        .prod (prod_reg),
        .res  (exec_res)
    );

    sialu_ram #(
        .WIDTH (32),
        .DEPTH (sialu_pkg::RF_DEPTH)
    ) u_rf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = out_data_reg;
    assign m_axis_tuser[0] = out_pair_reg;

    // Reads and write-backs of one instruction never share a cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !(ram_we && ram_re))
        else $error("register file read and write in the same cycle");

    // A read is only captured in the cycle after it was issued in an operand step.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> (state_reg == sialu_pkg::ST_READ || state_reg == sialu_pkg::ST_MUL))
        else $error("operand capture outside the read sequence");

    // A register pair is always followed by the second write-back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == sialu_pkg::ST_EXEC && exec_res.pair_written)
        |=> (state_reg == sialu_pkg::ST_WR_HI && ram_we))
        else $error("upper word of a register pair was not written");

    // A new result only appears after the hand-over state.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == sialu_pkg::ST_DONE))
        else $error("result presented without completing an instruction");

    // No instruction is taken while one is still being worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !rd_valid_reg && !ram_we)
        else $error("instruction accepted while the lane is busy");

endmodule

### test/simt_integer_alu_lane_tb.sv
// Self-checking testbench for the SIMT integer ALU lane.
// Depends on sialu_pkg and the simt_integer_alu_lane RTL; it needs no other file.
`timescale 1ns / 1ps

module simt_integer_alu_lane_tb;

    // One instruction as it travels on the slave side.
    typedef struct packed {
        sialu_pkg::mode_t mode;
        logic [4:0]       thread;
        logic [7:0]       dest;
        logic [31:0]      src_a;
        logic [31:0]      src_b;
        logic [63:0]      src_c;
        logic [2:0]       flags;
        logic [7:0]       lut;
        logic             wide;
        logic             shift_left;
    } instr_t;

    // One write-back report as it travels on the master side.
    typedef struct packed {
        logic [7:0]  written_reg;
        logic [31:0] low_word;
        logic [31:0] high_word;
        logic        pair_written;
    } writeback_t;

    logic         clk;
    logic         rst_n          = 1'b0;
    logic         s_axis_tvalid  = 1'b0;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata   = '0;
    logic [6:0]   s_axis_tuser   = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready  = 1'b0;
    logic [71:0]  m_axis_tdata;
    logic [0:0]   m_axis_tuser;

    // Shadow copy of the register file, together with a record of which entries
    // have been written, so that the stimulus never reads an undefined register.
    logic [31:0] shadow_rf     [sialu_pkg::NUM_THREADS][sialu_pkg::NUM_REGS];
    bit          reg_written   [sialu_pkg::NUM_THREADS][sialu_pkg::NUM_REGS];
    int          written_count [sialu_pkg::NUM_THREADS];
    logic [7:0]  last_dest     [sialu_pkg::NUM_THREADS];

    writeback_t  pending_writebacks[$];
    writeback_t  want_wb;
    int          mismatches = 0;
    int          sink_hold  = 0;
    bit          calm_phase = 1'b0;

    simt_integer_alu_lane u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Idle lengths: mostly none or short, now and then a long one. During a
    // calm phase neither side idles at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm_phase)
            return 0;
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("ERROR at %0t ns: %s", $realtime, msg);
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
            report($sformatf("%s expected %h, actual %h", name, want, got));
    endtask

    task automatic store_reg(input logic [4:0] th, input logic [7:0] r,
                             input logic [31:0] v);
        shadow_rf[th][r] = v;
        if (!reg_written[th][r])
        begin
            reg_written[th][r] = 1'b1;
            written_count[th]++;
        end
        last_dest[th] = r;
    endtask

    // Executes one instruction on the shadow register file and queues the write-back
    // report that the lane must produce for it, none for a no-operation. Every operand
    // is read before anything is written back, and register indices wrap at 256.
    task automatic predict_writeback(input instr_t ins);
        logic [31:0] opa;
        logic [31:0] opb;
        logic [31:0] opc;
        logic [31:0] lop;
        logic [63:0] addend;
        logic [63:0] sum;
        logic [63:0] funnel;
        logic [7:0]  c_next;
        logic [7:0]  d_next;
        writeback_t  wb;
        c_next = ins.src_c[7:0] + 8'd1;
        d_next = ins.dest + 8'd1;
        opa = ins.flags[sialu_pkg::IMM_A_BIT] ? ins.src_a
                                              : shadow_rf[ins.thread][ins.src_a[7:0]];
        opb = ins.flags[sialu_pkg::IMM_B_BIT] ? ins.src_b
                                              : shadow_rf[ins.thread][ins.src_b[7:0]];
        opc = ins.flags[sialu_pkg::IMM_C_BIT] ? ins.src_c[31:0]
                                              : shadow_rf[ins.thread][ins.src_c[7:0]];
        wb  = '0;
        wb.written_reg = ins.dest;
        case (ins.mode)
            sialu_pkg::MODE_MAD:
            begin
                // A register addend in wide form is the pair c, c+1.
                if (ins.flags[sialu_pkg::IMM_C_BIT])
                    addend = ins.src_c;
                else if (ins.wide)
                    addend = {shadow_rf[ins.thread][c_next], opc};
                else
                    addend = {32'h0, opc};
                sum = {32'h0, opa} * {32'h0, opb} + addend;
                wb.low_word = sum[31:0];
                store_reg(ins.thread, ins.dest, sum[31:0]);
                if (ins.wide)
                begin
                    wb.high_word    = sum[63:32];
                    wb.pair_written = 1'b1;
                    store_reg(ins.thread, d_next, sum[63:32]);
                end
            end
            sialu_pkg::MODE_LOP3:
            begin
                for (int k = 0; k < 32; k++)
                    lop[k] = ins.lut[{opa[k], opb[k], opc[k]}];
                wb.low_word = lop;
                store_reg(ins.thread, ins.dest, lop);
            end
            sialu_pkg::MODE_SHF:
            begin
                // The funnel always takes registers, whatever the flags say.
                funnel = {shadow_rf[ins.thread][ins.src_c[7:0]],
                          shadow_rf[ins.thread][ins.src_a[7:0]]};
                if (ins.src_b >= 32'd64)
                    funnel = '0;
                else if (ins.shift_left)
                    funnel = funnel << ins.src_b[5:0];
                else
                    funnel = funnel >> ins.src_b[5:0];
                wb.low_word = funnel[31:0];
                store_reg(ins.thread, ins.dest, funnel[31:0]);
            end
            default:
                return;
        endcase
        pending_writebacks.insert(pending_writebacks.size(), wb);
    endtask

    // Presents one instruction and holds it until the lane takes it. Back-to-back
    // transactions keep tvalid high, so it is only lowered when a gap follows.
    task automatic send_instr(input instr_t ins);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, ins.lut, ins.src_c, ins.src_b, ins.src_a,
                          ins.dest, ins.thread};
        s_axis_tuser  <= {ins.shift_left, ins.wide, ins.flags, ins.mode};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_writeback(ins);
    endtask

    function automatic instr_t make_instr(input sialu_pkg::mode_t mode,
                                          input logic [4:0] th,
                                          input logic [7:0] dest,
                                          input logic [31:0] a, input logic [31:0] b,
                                          input logic [63:0] c, input logic [2:0] flags,
                                          input logic [7:0] lut, input logic wide,
                                          input logic left);
        instr_t ins;
        ins.mode       = mode;
        ins.thread     = th;
        ins.dest       = dest;
        ins.src_a      = a;
        ins.src_b      = b;
        ins.src_c      = c;
        ins.flags      = flags;
        ins.lut        = lut;
        ins.wide       = wide;
        ins.shift_left = left;
        return ins;
    endfunction

    // Picks a register of the thread that already holds a value, quite often the
    // one written last so that read-after-write hazards are exercised.
    function automatic logic [7:0] pick_reg(input logic [4:0] th);
        logic [7:0] idx;
        if ($urandom_range(0, 2) == 0 && reg_written[th][last_dest[th]])
            return last_dest[th];
        idx = 8'($urandom);
        while (!reg_written[th][idx])
            idx++;
        return idx;
    endfunction

    // A random instruction whose register reads only touch written entries. The
    // upper bits of every register index are left random, as the lane ignores them.
    function automatic instr_t random_instr();
        instr_t     ins;
        logic [7:0] idx;
        logic [7:0] nxt;
        int         r;
        int         tries;
        r = $urandom_range(0, 99);
        ins = make_instr(sialu_pkg::MODE_NOP, 5'($urandom), 8'($urandom), $urandom,
                         $urandom, {$urandom, $urandom}, 3'($urandom), 8'($urandom),
                         1'($urandom), 1'($urandom));
        if (r < 38)
            ins.mode = sialu_pkg::MODE_MAD;
        else if (r < 70)
            ins.mode = sialu_pkg::MODE_LOP3;
        else if (r < 95)
            ins.mode = sialu_pkg::MODE_SHF;
        if (ins.mode == sialu_pkg::MODE_SHF && $urandom_range(0, 4) != 0)
            ins.src_b = $urandom_range(0, 70);
        // A thread with nothing written can only take immediate operands.
        if (ins.mode != sialu_pkg::MODE_NOP && written_count[ins.thread] == 0)
        begin
            ins.mode  = ($urandom_range(0, 1) == 0) ? sialu_pkg::MODE_MAD
                                                    : sialu_pkg::MODE_LOP3;
            ins.flags = 3'b111;
        end
        if (ins.mode == sialu_pkg::MODE_SHF)
        begin
            ins.src_a[7:0] = pick_reg(ins.thread);
            ins.src_c[7:0] = pick_reg(ins.thread);
        end
        else if (ins.mode != sialu_pkg::MODE_NOP)
        begin
            if (!ins.flags[sialu_pkg::IMM_A_BIT])
                ins.src_a[7:0] = pick_reg(ins.thread);
            if (!ins.flags[sialu_pkg::IMM_B_BIT])
                ins.src_b[7:0] = pick_reg(ins.thread);
            if (!ins.flags[sialu_pkg::IMM_C_BIT])
            begin
                idx = pick_reg(ins.thread);
                if (ins.mode == sialu_pkg::MODE_MAD && ins.wide)
                begin
                    // The addend pair needs its upper register written as well.
                    tries = 0;
                    nxt   = idx + 8'd1;
                    while (!reg_written[ins.thread][nxt] && tries < 8)
                    begin
                        idx = pick_reg(ins.thread);
                        nxt = idx + 8'd1;
                        tries++;
                    end
                    if (!reg_written[ins.thread][nxt])
                        ins.flags[sialu_pkg::IMM_C_BIT] = 1'b1;
                end
                if (!ins.flags[sialu_pkg::IMM_C_BIT])
                    ins.src_c[7:0] = idx;
            end
        end
        return ins;
    endfunction

    task automatic test_multiply_add();
        // Immediate extremes, narrow and wide, then register sources including a
        // wide addend pair that wraps from register 255 to register 0.
        send_instr(make_instr(sialu_pkg::MODE_MAD, 5'd0, 8'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              64'hFFFF_FFFF_FFFF_FFFF, 3'b111, 8'h00, 1'b0, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_MAD, 5'd0, 8'd10, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              64'hFFFF_FFFF_FFFF_FFFF, 3'b111, 8'h00, 1'b1, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_MAD, 5'd0, 8'd1, 32'h0, 32'h0, 64'h0, 3'b111,
                              8'h00, 1'b1, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_MAD, 5'd0, 8'd255, 32'h1234_5678, 32'h9ABC_DEF0,
                              64'h0123_4567_89AB_CDEF, 3'b111, 8'h00, 1'b1, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_MAD, 5'd0, 8'd20, 32'd10, 32'd11, 64'd255, 3'b000,
                              8'h00, 1'b1, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_MAD, 5'd0, 8'd21, 32'd0, 32'd1, 64'd2, 3'b000,
                              8'h00, 1'b0, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_MAD, 5'd31, 8'd7, 32'hFFFF_FFFF, 32'h8000_0001,
                              64'h8000_0000_0000_0000, 3'b111, 8'h00, 1'b1, 1'b1));
    endtask

    task automatic test_table_logic();
        // Constant tables, AND, NOR, majority and parity; the immediate c carries
        // set upper bits that the logic must ignore.
        send_instr(make_instr(sialu_pkg::MODE_LOP3, 5'd0, 8'd30, 32'd10, 32'd11, 64'd20,
                              3'b000, 8'h00, 1'b0, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_LOP3, 5'd0, 8'd31, 32'd10, 32'd11, 64'd20,
                              3'b000, 8'hFF, 1'b1, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_LOP3, 5'd0, 8'd32, 32'd255, 32'd11, 64'd20,
                              3'b000, 8'h80, 1'b0, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_LOP3, 5'd0, 8'd33, 32'hF0F0_F0F0, 32'hCCCC_CCCC,
                              64'd20, 3'b110, 8'h01, 1'b0, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_LOP3, 5'd0, 8'd34, 32'd255, 32'd20,
                              64'hFFFF_FFFF_AAAA_5555, 3'b001, 8'hE8, 1'b0, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_LOP3, 5'd0, 8'd35, 32'hFFFF_0000, 32'h00FF_FF00,
                              64'h1234_5678_0F0F_0F0F, 3'b111, 8'h96, 1'b0, 1'b0));
    endtask

    task automatic test_funnel_shift();
        // Both directions across the word boundary, the last legal amount, and
        // amounts of 64 and above that clear the result.
        send_instr(make_instr(sialu_pkg::MODE_SHF, 5'd0, 8'd40, 32'd255, 32'd0, 64'd11,
                              3'b000, 8'h00, 1'b0, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_SHF, 5'd0, 8'd41, 32'd255, 32'd0, 64'd11,
                              3'b111, 8'h00, 1'b0, 1'b1));
        send_instr(make_instr(sialu_pkg::MODE_SHF, 5'd0, 8'd42, 32'd255, 32'd31, 64'd11,
                              3'b000, 8'h00, 1'b0, 1'b1));
        send_instr(make_instr(sialu_pkg::MODE_SHF, 5'd0, 8'd43, 32'd255, 32'd32, 64'd11,
                              3'b000, 8'h00, 1'b0, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_SHF, 5'd0, 8'd44, 32'd255, 32'd63, 64'd11,
                              3'b000, 8'h00, 1'b0, 1'b1));
        send_instr(make_instr(sialu_pkg::MODE_SHF, 5'd0, 8'd45, 32'd255, 32'd64, 64'd11,
                              3'b000, 8'h00, 1'b0, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_SHF, 5'd0, 8'd46, 32'd255, 32'hFFFF_FFFF, 64'd11,
                              3'b000, 8'h00, 1'b0, 1'b1));
    endtask

    task automatic test_index_wrap();
        // Register indices with high bits set select register index modulo 256.
        send_instr(make_instr(sialu_pkg::MODE_SHF, 5'd0, 8'd47, 32'hFFFF_FF0B, 32'd13,
                              64'hFFFF_FFFF_FFFF_FFFF, 3'b000, 8'h00, 1'b0, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_MAD, 5'd0, 8'd48, 32'h8000_000A, 32'hDEAD_BE0B,
                              64'hF00D_0000_0000_01FF, 3'b000, 8'h00, 1'b1, 1'b0));
    endtask

    task automatic test_nop();
        // Mode 3 is swallowed without a write-back, even between real work.
        send_instr(make_instr(sialu_pkg::MODE_NOP, 5'd31, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                              64'hFFFF_FFFF_FFFF_FFFF, 3'b111, 8'hFF, 1'b1, 1'b1));
        send_instr(make_instr(sialu_pkg::MODE_MAD, 5'd31, 8'd9, 32'd3, 32'd5, 64'd7, 3'b111,
                              8'h00, 1'b0, 1'b0));
        send_instr(make_instr(sialu_pkg::MODE_NOP, 5'd0, 8'd0, 32'h0, 32'h0, 64'h0, 3'b000,
                              8'h00, 1'b0, 1'b0));
    endtask

    task automatic test_random_mix(input int count);
        for (int n = 0; n < count; n++)
        begin
            // Every so often switch between idling and flat-out stretches.
            if (n % 150 == 0)
                calm_phase = ($urandom_range(0, 2) == 0);
            send_instr(random_instr());
        end
        calm_phase = 1'b0;
    endtask

    task automatic test_drain_pause();
        // The sender stops until the lane has handed back every write-back, then
        // carries on after a short hold-off.
        repeat (20) send_instr(random_instr());
        s_axis_tvalid <= 1'b0;
        while (pending_writebacks.size() != 0)
            @(posedge clk);
        repeat ($urandom_range(1, 10)) @(posedge clk);
        repeat (20) send_instr(random_instr());
    endtask

    // Master side: tready drops for random stretches, sometimes for long ones.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (sink_hold > 0)
            begin
                m_axis_tready <= 1'b0;
                sink_hold--;
            end
            else
            begin
                m_axis_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    sink_hold = pick_gap();
            end
        end
    end

    // Each write-back transaction is compared, field by field, with the oldest
    // pending prediction. Values are sampled at the edge, before any update.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_writebacks.size() == 0)
                report($sformatf("unexpected write-back to register %0d",
                                 m_axis_tdata[7:0]));
            else
            begin
                want_wb = pending_writebacks.pop_front();
                check_field("written_reg", 64'(want_wb.written_reg),
                            64'(m_axis_tdata[7:0]));
                check_field("low_word", 64'(want_wb.low_word), 64'(m_axis_tdata[39:8]));
                check_field("high_word", 64'(want_wb.high_word), 64'(m_axis_tdata[71:40]));
                check_field("pair_written", 64'(want_wb.pair_written),
                            64'(m_axis_tuser[0]));
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_multiply_add();
        test_table_logic();
        test_funnel_shift();
        test_index_wrap();
        test_nop();
        test_drain_pause();
        test_random_mix(1640);
        s_axis_tvalid <= 1'b0;
        while (pending_writebacks.size() != 0)
            @(posedge clk);
        // This margin outlasts a wide instruction, so it catches any stray
        // write-back that follows the last expected one.
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run with every gap at its longest.
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
